// File: rtl/core/teb_pkg.sv
// types, constants and codes shared by the timed event buffer modules
package teb_pkg;

	localparam int DEPTH      = 16;
	localparam int CODE_BITS  = 8;
	localparam int OP_W       = 3;
	localparam int STAMP_W    = 32;
	localparam int WIN_W      = 16;
	localparam int ENTRY_W    = 5;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(30);

	// opcodes as they arrive on the command port
	typedef enum logic [OP_W-1:0] {
		OPC_TICK    = 3'd0,
		OPC_RECORD  = 3'd1,
		OPC_CONSUME = 3'd2,
		OPC_QUERY   = 3'd3,
		OPC_CLEAR   = 3'd4
	} op_code_t;

	// classified operation handed to the back end
	typedef enum logic [2:0] {
		K_TICK,
		K_RECORD,
		K_CONSUME,
		K_QUERY,
		K_CLEAR,
		K_NOP
	} op_kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_TRIM
	} back_state_t;

	typedef struct packed {
		logic [OP_W-1:0]      opcode;
		logic [CODE_BITS-1:0] event_code;
	} cmd_t;

	typedef struct packed {
		logic               found;
		logic               dropped_oldest;
		logic [ENTRY_W-1:0] entry_count;
	} result_t;

	typedef struct packed {
		op_kind_t             kind;
		logic [CODE_BITS-1:0] code;
		logic                 code_nz;
	} queue_item_t;

	// queue head handshake toward the back end
	typedef struct packed {
		logic        vld;
		queue_item_t item;
	} queue_head_t;

endpackage

// File: rtl/core/teb_front.sv
// front end: accepts command beats and classifies them into queue items
module teb_front import teb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	input  logic        q_full,
	output logic        push,
	output queue_item_t push_item
);

	logic        vld_s1;
	queue_item_t item_s1;
	queue_item_t item_d;
	logic        accept;
	logic        drain;

	// decode opcode and flag the empty event code
	always_comb begin
		item_d.code    = cmd.event_code;
		item_d.code_nz = (cmd.event_code != '0);
		unique case (cmd.opcode)
			OPC_TICK:    item_d.kind = K_TICK;
			OPC_RECORD:  item_d.kind = K_RECORD;
			OPC_CONSUME: item_d.kind = K_CONSUME;
			OPC_QUERY:   item_d.kind = K_QUERY;
			OPC_CLEAR:   item_d.kind = K_CLEAR;
			default:     item_d.kind = K_NOP;
		endcase
	end

	// stage register moves into the queue whenever there is room
	assign drain  = vld_s1 && !q_full;
	assign busy   = vld_s1 && q_full;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (drain) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	assign push      = drain;
	assign push_item = item_s1;

endmodule

// File: rtl/core/teb_queue.sv
// short queue between the front and back ends
module teb_queue import teb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  queue_item_t push_item,
	output logic        full,
	input  logic        pop,
	output queue_head_t head
);

	queue_item_t       slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign head.vld  = (cnt_q != '0);
	assign head.item = slots_q[rd_ptr_q];
	assign do_pop    = pop && head.vld;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: rtl/core/teb_back.sv
// back end: slot cell chain, tick clock, window register and result beat
module teb_back import teb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  queue_head_t      head,
	output logic             pop,
	input  logic             cfg_valid,
	input  logic [WIN_W-1:0] cfg_data,
	output logic             done,
	output result_t          result
);

	back_state_t state_q, state_d;

	logic [CODE_BITS-1:0] code_q  [DEPTH];
	logic [STAMP_W-1:0]   stamp_q [DEPTH];
	logic [CODE_BITS-1:0] code_d  [DEPTH];
	logic [STAMP_W-1:0]   stamp_d [DEPTH];
	logic [CNT_W-1:0]     count_q, count_d;
	logic [STAMP_W-1:0]   now_q, now_d;
	logic [WIN_W-1:0]     window_q;
	logic                 done_q;
	result_t              result_q;

	logic [DEPTH-1:0]     in_win;
	logic [DEPTH-1:0]     match;
	logic [IDX_W-1:0]     match_idx;
	logic                 any_match;
	logic                 full;
	logic                 head_expired;

	logic                 exec;
	logic                 emit;
	logic                 shift_en;
	logic [IDX_W-1:0]     shift_from;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	logic                 found_d;
	logic                 dropped_d;
	logic [STAMP_W-1:0]   age [DEPTH];

	// per cell age and match compare
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			age[i]    = now_q - stamp_q[i];
			in_win[i] = (age[i][STAMP_W-1:WIN_W] == '0) && (age[i][WIN_W-1:0] <= window_q);
			match[i]  = (CNT_W'(i) < count_q) && in_win[i] && (code_q[i] == head.item.code);
		end
	end

	// newest matching cell wins
	always_comb begin
		match_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match[i]) begin
				match_idx = IDX_W'(i);
			end
		end
	end

	assign any_match    = head.item.code_nz && (match != '0);
	assign full         = (count_q == CNT_W'(DEPTH));
	assign head_expired = (count_q != '0) && !in_win[0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head.vld && head.item.kind == K_TICK) begin
					state_d = BK_TRIM;
				end
			end
			BK_TRIM: begin
				if (!head_expired) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop  = 1'b0;
		exec = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop  = head.vld;
				exec = head.vld;
				emit = head.vld && head.item.kind != K_TICK;
			end
			BK_TRIM: begin
				emit = !head_expired;
			end
			default: ;
		endcase
	end

	// operation decode into cell chain controls
	always_comb begin
		shift_en   = 1'b0;
		shift_from = '0;
		wr_en      = 1'b0;
		wr_idx     = count_q[IDX_W-1:0];
		found_d    = 1'b0;
		dropped_d  = 1'b0;
		count_d    = count_q;
		now_d      = now_q;
		if (state_q == BK_TRIM) begin
			if (head_expired) begin
				shift_en = 1'b1;
				count_d  = count_q - 1'b1;
			end
		end else if (exec) begin
			unique case (head.item.kind)
				K_TICK: begin
					now_d = now_q + 1'b1;
				end
				K_RECORD: begin
					if (head.item.code_nz) begin
						wr_en = 1'b1;
						if (full) begin
							shift_en  = 1'b1;
							wr_idx    = IDX_W'(DEPTH - 1);
							dropped_d = 1'b1;
						end else begin
							count_d = count_q + 1'b1;
						end
					end
				end
				K_CONSUME: begin
					if (any_match) begin
						shift_en   = 1'b1;
						shift_from = match_idx;
						count_d    = count_q - 1'b1;
						found_d    = 1'b1;
					end
				end
				K_QUERY: begin
					found_d = any_match;
				end
				K_CLEAR: begin
					count_d = '0;
				end
				K_NOP: ;
				default: ;
			endcase
		end
	end

	// cell chain: close the gap from shift_from upward, then write the new entry
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			code_d[i]  = code_q[i];
			stamp_d[i] = stamp_q[i];
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			if (shift_en && IDX_W'(i) >= shift_from) begin
				code_d[i]  = code_q[i + 1];
				stamp_d[i] = stamp_q[i + 1];
			end
		end
		if (wr_en) begin
			code_d[wr_idx]  = head.item.code;
			stamp_d[wr_idx] = now_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			count_q  <= '0;
			now_q    <= '0;
			window_q <= WIN_RESET;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			now_q   <= now_d;
			done_q  <= emit;
			if (cfg_valid) begin
				window_q <= cfg_data;
			end
		end
	end

	// slot payload and result beat
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			code_q[i]  <= code_d[i];
			stamp_q[i] <= stamp_d[i];
		end
		if (emit) begin
			result_q.found          <= found_d;
			result_q.dropped_oldest <= dropped_d;
			result_q.entry_count    <= ENTRY_W'(count_d);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/core/timed_event_buffer_top.sv
// top level of the timed event buffer: front end, queue, back end
//
// channel   direction  handshake                      payload
// command   in         start, busy (taken: start&!busy) cmd (cmd_t)
// result    out        done, one cycle strobe         result (result_t)
// config    in         cfg_valid, cfg_ready           cfg_data (window, 16 bits)
//
// a command passes through the front stage register and waits there while the two entry queue is full;
//   with the queue empty, it goes on through a queue slot to the back end, which registers done
// record, consume, query, clear and unknown ops are carried out in the idle state, which pops them and emits the result
// tick advances time in the idle state, then the trim state shifts each expired entry out of the head
//   of the cell chain one at a time and emits the result once the head entry is inside the window
// busy rises when the front stage holds a command and the queue is full
// arst_n clears the buffer, the tick count and sets the window to 30
// done is never held off: it is high for exactly one cycle per result, and result holds until the next one
module timed_event_buffer_top import teb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             done,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [WIN_W-1:0] cfg_data
);

	logic        q_full;
	logic        push;
	queue_item_t push_item;
	logic        pop;
	queue_head_t head;

	// window writes are taken at any time
	assign cfg_ready = 1'b1;

	teb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	teb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	teb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

`ifndef SYNTH
	// a drop only happens on a record into a full buffer
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.dropped_oldest |-> result.entry_count == ENTRY_W'(DEPTH))
		else $error("drop reported with buffer not full");

	// found and dropped come from different ops
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.found && result.dropped_oldest))
		else $error("found and dropped both set");

	// the count never exceeds the buffer depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.entry_count <= ENTRY_W'(DEPTH))
		else $error("entry count beyond depth");

	// a full queue with a held command stalls the command port
	a_busy_queue: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_full)
		else $error("busy without a full queue");
`endif

endmodule

// File: tb/sv/timed_event_buffer_top_tb.sv
// self-checking testbench for the timed event buffer: predicting scoreboard, directed and random commands
module timed_event_buffer_top_tb;
	import teb_pkg::*;

	// opcodes outside the defined set, which the block must leave without effect
	localparam logic [OP_W-1:0] OPC_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OPC_SPARE_LAST  = 3'd7;
	localparam int              STALL_LIMIT     = 2000;
	localparam int              SETTLE_CYCLES   = 24;

	// tracks buffer contents, predicts each result beat and checks it in order
	class event_buffer_scoreboard;
		logic [CODE_BITS-1:0] codes  [DEPTH];
		logic [STAMP_W-1:0]   stamps [DEPTH];
		int unsigned          held;
		logic [STAMP_W-1:0]   ticks;
		logic [WIN_W-1:0]     window;
		result_t              expected_q [$];
		int unsigned          errors;

		function new();
			held   = 0;
			ticks  = '0;
			window = WIN_RESET;
			errors = 0;
		endfunction

		function void set_window(logic [WIN_W-1:0] w);
			window = w;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// age is an unsigned difference that wraps with the tick count
		function bit is_fresh(int unsigned i);
			logic [STAMP_W-1:0] age;
			age = ticks - stamps[i];
			return age <= STAMP_W'(window);
		endfunction

		// remove one entry and close the gap, keeping order
		function void remove_entry(int unsigned idx);
			for (int unsigned i = idx; i + 1 < held; i++) begin
				codes[i]  = codes[i + 1];
				stamps[i] = stamps[i + 1];
			end
			held--;
		endfunction

		// apply one accepted command and queue the result it must produce
		function void note_command(cmd_t c);
			result_t     r;
			int unsigned kept;
			r = '0;
			case (c.opcode)
				OPC_TICK: begin
					ticks = ticks + 1;
					kept = 0;
					for (int unsigned i = 0; i < held; i++) begin
						if (is_fresh(i)) begin
							codes[kept]  = codes[i];
							stamps[kept] = stamps[i];
							kept++;
						end
					end
					held = kept;
				end
				OPC_RECORD: begin
					if (c.event_code != '0) begin
						if (held >= DEPTH) begin
							remove_entry(0);
							r.dropped_oldest = 1'b1;
						end
						codes[held]  = c.event_code;
						stamps[held] = ticks;
						held++;
					end
				end
				OPC_CONSUME: begin
					if (c.event_code != '0) begin
						// newest first; stale matches are skipped, not removed
						for (int i = int'(held) - 1; i >= 0; i--) begin
							if (codes[i] == c.event_code && is_fresh(i)) begin
								remove_entry(i);
								r.found = 1'b1;
								break;
							end
						end
					end
				end
				OPC_QUERY: begin
					if (c.event_code != '0) begin
						for (int unsigned i = 0; i < held; i++) begin
							if (codes[i] == c.event_code && is_fresh(i)) begin
								r.found = 1'b1;
								break;
							end
						end
					end
				end
				OPC_CLEAR: begin
					held = 0;
				end
				default: begin
				end
			endcase
			r.entry_count = ENTRY_W'(held);
			expected_q.push_back(r);
		endfunction

		// compare one result beat with the oldest prediction
		function void check_result(result_t r);
			result_t e;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: found=%0d dropped_oldest=%0d entry_count=%0d",
					r.found, r.dropped_oldest, r.entry_count);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (r.found !== e.found) begin
				$error("found: expected %0d, got %0d", e.found, r.found);
				errors++;
			end
			if (r.dropped_oldest !== e.dropped_oldest) begin
				$error("dropped_oldest: expected %0d, got %0d", e.dropped_oldest, r.dropped_oldest);
				errors++;
			end
			if (r.entry_count !== e.entry_count) begin
				$error("entry_count: expected %0d, got %0d", e.entry_count, r.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	cmd_t             cmd       = '0;
	logic             done;
	result_t          result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [WIN_W-1:0] cfg_data  = '0;

	event_buffer_scoreboard sb = new();
	int unsigned            quiet_cycles = 0;
	bit                     idling_on;

	timed_event_buffer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// present a command and hold it until taken; start stays high for a following beat
	task automatic send(logic [OP_W-1:0] op, logic [CODE_BITS-1:0] code);
		cmd_t c;
		c.opcode     = op;
		c.event_code = code;
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(c);
	endtask

	task automatic pause(int unsigned n);
		if (n == 0)
			return;
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// sender gap: mostly short, a few long
	task automatic random_gap();
		int unsigned r;
		if (!idling_on)
			return;
		r = $urandom_range(0, 99);
		if (r < 55)
			pause(0);
		else if (r < 90)
			pause($urandom_range(1, 3));
		else
			pause($urandom_range(8, 40));
	endtask

	// stop sending and wait until every predicted result has arrived
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// window register write, only issued while the block is idle
	task automatic write_window(logic [WIN_W-1:0] w);
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_window(w);
		@(posedge clk);
	endtask

	// random traffic, biased to a few codes so records meet consumes and queries
	task automatic random_phase(int unsigned beats, int unsigned code_span);
		int unsigned          r;
		logic [OP_W-1:0]      op;
		logic [CODE_BITS-1:0] code;
		for (int unsigned k = 0; k < beats; k++) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				op = OPC_TICK;
			else if (r < 60)
				op = OPC_RECORD;
			else if (r < 76)
				op = OPC_CONSUME;
			else if (r < 92)
				op = OPC_QUERY;
			else if (r < 95)
				op = OPC_CLEAR;
			else
				op = OP_W'($urandom_range(OPC_SPARE_FIRST, OPC_SPARE_LAST));
			r = $urandom_range(0, 99);
			if (r < 6)
				code = '0;
			else if (r < 85)
				code = CODE_BITS'($urandom_range(1, code_span));
			else
				code = CODE_BITS'($urandom_range(0, 255));
			send(op, code);
			random_gap();
			if ($urandom_range(0, 199) == 0)
				settle();
		end
	endtask

	// stimulus
	initial begin
		idling_on = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill to capacity, then one more record pushes out the oldest
		send(OPC_RECORD, 8'hFF);
		for (int unsigned i = 1; i < DEPTH; i++)
			send(OPC_RECORD, CODE_BITS'(i));
		send(OPC_RECORD, 8'h80);
		send(OPC_QUERY, 8'hFF);
		send(OPC_CONSUME, 8'h80);
		send(OPC_CONSUME, 8'h80);
		// code zero does nothing
		send(OPC_QUERY, 8'h00);
		send(OPC_CONSUME, 8'h00);
		send(OPC_RECORD, 8'h00);
		// undefined opcodes
		send(OPC_SPARE_FIRST, 8'h01);
		send(OPC_SPARE_LAST, 8'h02);
		send(OPC_CLEAR, 8'h00);
		send(OPC_TICK, 8'h00);
		// stale match left behind by narrowing the window without a tick
		send(OPC_RECORD, 8'h05);
		send(OPC_TICK, 8'h00);
		send(OPC_TICK, 8'h00);
		settle();
		write_window(16'd1);
		send(OPC_CONSUME, 8'h05);
		send(OPC_QUERY, 8'h05);
		send(OPC_TICK, 8'h00);
		settle();

		// random phases across window settings, extremes included
		write_window(16'hFFFF);
		idling_on = 1'b1;
		random_phase(300, 6);
		settle();
		write_window(16'd0);
		idling_on = 1'b0;
		random_phase(300, 4);
		settle();
		write_window(16'd3);
		idling_on = 1'b1;
		random_phase(300, 4);
		settle();
		write_window(WIN_W'($urandom_range(1, 12)));
		random_phase(300, 3);
		settle();
		write_window(WIN_W'($urandom_range(0, 65535)));
		idling_on = 1'b0;
		random_phase(250, 5);
		settle();
		write_window(WIN_RESET);
		idling_on = 1'b1;
		random_phase(300, 4);
		settle();

		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: timed_event_buffer_top.f
rtl/core/teb_pkg.sv
rtl/core/teb_front.sv
rtl/core/teb_queue.sv
rtl/core/teb_back.sv
rtl/core/timed_event_buffer_top.sv
tb/sv/timed_event_buffer_top_tb.sv
